// ----- rtl/qvs_pkg.sv -----
// ----------------------------------------------------------------------------
// qvs_pkg: shared types for the quaternion vertex skinning block
// Payload structs, controller command and status, FSM state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package qvs_pkg;

   localparam int unsigned QuatW  = 16;
   localparam int unsigned PosW   = 32;
   localparam int unsigned FactW  = 17;
   localparam int unsigned AccW   = 48;
   localparam int unsigned FracQ  = 14;
   localparam int unsigned FracF  = 16;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [31:0] joint_pos_x;
      logic signed [31:0] joint_pos_y;
      logic signed [31:0] joint_pos_z;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
      logic        [16:0] blend_factor;
      logic               last_weight;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
   } rsp_type;

   typedef struct packed {
      logic load;     // capture input item
      logic t_mul;    // q x v partial products
      logic t_rnd;    // t = 2 (q x v), rounded
      logic r_mul;    // w t and q x t products
      logic r_sum;    // rotated offset plus joint position
      logic scale;    // times blend factor
      logic accum;    // saturating accumulate
      logic finish;   // load output register, update box
   } cmd_type;

   typedef struct packed {
      logic mode;     // weighted mode
      logic last;     // captured last_weight
      logic out_free; // output register can take a result
   } sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TMUL,
      ST_TRND,
      ST_RMUL,
      ST_RSUM,
      ST_SCALE,
      ST_ACC,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/qvs_ctrl.sv -----
// ----------------------------------------------------------------------------
// qvs_ctrl: sequencing controller
// Steps one item through the datapath and waits for a free output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qvs_ctrl
   import qvs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.mode ? ST_TMUL : ST_FINISH;
            end
         end
         ST_TMUL:  state_in = ST_TRND;
         ST_TRND:  state_in = ST_RMUL;
         ST_RMUL:  state_in = ST_RSUM;
         ST_RSUM:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_ACC;
         ST_ACC:   state_in = sts.last ? ST_FINISH : ST_IDLE;
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_TMUL:   cmd.t_mul  = 1'b1;
         ST_TRND:   cmd.t_rnd  = 1'b1;
         ST_RMUL:   cmd.r_mul  = 1'b1;
         ST_RSUM:   cmd.r_sum  = 1'b1;
         ST_SCALE:  cmd.scale  = 1'b1;
         ST_ACC:    cmd.accum  = 1'b1;
         ST_FINISH: cmd.finish = sts.out_free;
         default:   cmd        = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/qvs_dpath.sv -----
// ----------------------------------------------------------------------------
// qvs_dpath: skinning datapath
// Three lanes of rotate, translate, scale, accumulate; box and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qvs_dpath
   import qvs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire logic    csr_write,
   input  wire logic    csr_data,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int unsigned PW  = QuatW + PosW;      // q * v
   localparam int unsigned TW  = PW + 3 - FracQ;    // t
   localparam int unsigned MW  = QuatW + TW;        // q * t
   localparam int unsigned RW  = MW + 4 - FracQ;    // rotated offset
   localparam int unsigned SW  = RW + 1;            // plus joint position
   localparam int unsigned XW  = SW + FactW + 1;    // times factor
   localparam int unsigned TMW = XW + 1 - FracF;    // scaled term

   req_type item_ff;
   logic    mode_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic signed [PosW-1:0]  v [3];
   logic signed [PosW-1:0]  jp [3];
   logic signed [QuatW-1:0] q [3];
   logic signed [PosW-1:0]  pos [3];

   logic signed [PW-1:0]    pa_ff [3];
   logic signed [PW-1:0]    pb_ff [3];
   logic signed [TW-1:0]    t_ff [3];
   logic signed [MW-1:0]    m0_ff [3];
   logic signed [MW-1:0]    m1_ff [3];
   logic signed [MW-1:0]    m2_ff [3];
   logic signed [SW-1:0]    s_ff [3];
   logic signed [XW-1:0]    x_ff [3];
   logic signed [AccW-1:0]  acc_ff [3];
   logic signed [PosW-1:0]  lo_ff [3];
   logic signed [PosW-1:0]  hi_ff [3];
   logic signed [PosW-1:0]  lo_in [3];
   logic signed [PosW-1:0]  hi_in [3];

   assign v[0]  = item_ff.offset_x;
   assign v[1]  = item_ff.offset_y;
   assign v[2]  = item_ff.offset_z;
   assign jp[0] = item_ff.joint_pos_x;
   assign jp[1] = item_ff.joint_pos_y;
   assign jp[2] = item_ff.joint_pos_z;
   assign q[0]  = item_ff.quat_x;
   assign q[1]  = item_ff.quat_y;
   assign q[2]  = item_ff.quat_z;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_write) begin
         mode_ff <= csr_data;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      logic signed [PW+2:0]   t_wide;
      logic signed [MW:0]     m0_wide;
      logic signed [MW+1:0]   m12_wide;
      logic signed [RW-1:0]   r_val;
      logic signed [XW:0]     x_wide;
      logic signed [TMW-1:0]  term;
      logic signed [AccW:0]   sum;
      logic signed [AccW-1:0] sum_sat;
      logic signed [PosW-1:0] acc_sat;

      always_comb begin
         t_wide   = ((PW+3)'(pa_ff[i]) - (PW+3)'(pb_ff[i])) <<< 1;
         t_wide   = t_wide + (PW+3)'(1 << (FracQ - 1));
         m0_wide  = (MW+1)'(m0_ff[i]) + (MW+1)'(1 << (FracQ - 1));
         m12_wide = (MW+2)'(m1_ff[i]) - (MW+2)'(m2_ff[i])
                  + (MW+2)'(1 << (FracQ - 1));
         r_val    = RW'(v[i]) + RW'($signed(m0_wide[MW:FracQ]))
                  + RW'($signed(m12_wide[MW+1:FracQ]));
         x_wide   = (XW+1)'(x_ff[i]) + (XW+1)'(1 << (FracF - 1));
         term     = x_wide[XW:FracF];
         sum      = (AccW+1)'(acc_ff[i]) + (AccW+1)'(term);
         if (sum[AccW] != sum[AccW-1]) begin
            sum_sat = {sum[AccW], {(AccW-1){~sum[AccW]}}};
         end else begin
            sum_sat = sum[AccW-1:0];
         end
         // 48 to 32 bit saturation of the finished vertex
         if (acc_ff[i][AccW-1:PosW-1] == {(AccW-PosW+1){acc_ff[i][AccW-1]}}) begin
            acc_sat = acc_ff[i][PosW-1:0];
         end else begin
            acc_sat = {acc_ff[i][AccW-1], {(PosW-1){~acc_ff[i][AccW-1]}}};
         end
         pos[i]   = mode_ff ? acc_sat : v[i];
         lo_in[i] = (pos[i] < lo_ff[i]) ? pos[i] : lo_ff[i];
         hi_in[i] = (pos[i] > hi_ff[i]) ? pos[i] : hi_ff[i];
      end

      always_ff @(posedge clock) begin
         if (cmd.t_mul) begin
            pa_ff[i] <= q[J] * v[K];
            pb_ff[i] <= q[K] * v[J];
         end
         if (cmd.t_rnd) begin
            t_ff[i] <= t_wide[PW+2:FracQ];
         end
         if (cmd.r_mul) begin
            m0_ff[i] <= item_ff.quat_w * t_ff[i];
            m1_ff[i] <= q[J] * t_ff[K];
            m2_ff[i] <= q[K] * t_ff[J];
         end
         if (cmd.r_sum) begin
            s_ff[i] <= SW'(r_val) + SW'(jp[i]);
         end
         if (cmd.scale) begin
            x_ff[i] <= s_ff[i] * $signed({1'b0, item_ff.blend_factor});
         end
         if (reset) begin
            acc_ff[i] <= '0;
            lo_ff[i]  <= {1'b0, {(PosW-1){1'b1}}};
            hi_ff[i]  <= {1'b1, {(PosW-1){1'b0}}};
         end else begin
            if (cmd.accum) begin
               acc_ff[i] <= sum_sat;
            end else if (cmd.finish) begin
               acc_ff[i] <= '0;
            end
            if (cmd.finish) begin
               lo_ff[i] <= lo_in[i];
               hi_ff[i] <= hi_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_ff <= '{pos[0], pos[1], pos[2], lo_in[0], lo_in[1], lo_in[2],
                     hi_in[0], hi_in[1], hi_in[2]};
      end
   end

   assign sts.mode     = mode_ff;
   assign sts.last     = item_ff.last_weight;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/quaternion_vertex_skinning.sv -----
// ----------------------------------------------------------------------------
// quaternion_vertex_skinning: quaternion linear blend skinning with bbox
// Top level; joins the sequencing controller and the skinning datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one skinning weight per item (valid/ready). Each weight carries
//            the joint quaternion (Q1.14), joint position and offset (Q24.8)
//            and a Q1.16 blend factor. last_weight closes a vertex.
//   rsp_*  : one item per finished vertex: position (saturated in weighted
//            mode) plus the running bounding box after merging that vertex.
//   csr_*  : weighted_mode, written with csr_write while idle. Mode 0
//            passes the offset through as the vertex, one result per item.
// Timing:
//   Weighted mode: per weight, load, two multiply/round passes of
//   the rotation, translate, scale, accumulate; a last weight then also
//   loads the output register. Pass-through: load, then output register.
//   The single sequencer walks each weight through the shared three-lane
//   datapath one step per cycle unless stalled, and takes items only in idle.
// Reset (synchronous): accumulator cleared, box set empty, mode = weighted.
// Stall: a result waits in the output register; the next item is still taken
//   and worked on, and the sequencer holds only at the final step until the
//   output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vertex_skinning
   import qvs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_write,
   input  wire logic    csr_data
);

   cmd_type cmd;   // controller to datapath step strobes
   sts_type sts;   // mode, last flag, output register free

   qvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   qvs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/qvs_checker.sv -----
// ----------------------------------------------------------------------------
// qvs_checker: port-level checks for quaternion_vertex_skinning
// Bound to the top level; looks at its ports only.
// ----------------------------------------------------------------------------
`default_nettype none

module qvs_checker
   import qvs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item taken while busy");

   a_vert_in_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.vert_x >= rsp_data.box_min_x &&
                     rsp_data.vert_x <= rsp_data.box_max_x &&
                     rsp_data.vert_y >= rsp_data.box_min_y &&
                     rsp_data.vert_y <= rsp_data.box_max_y &&
                     rsp_data.vert_z >= rsp_data.box_min_z &&
                     rsp_data.vert_z <= rsp_data.box_max_z))
      else $error("vertex outside bounding box");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_data))
      else $error("result changed while stalled");

endmodule

bind quaternion_vertex_skinning qvs_checker u_qvs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
